// ===== hdl/csvfs_pkg.sv =====
package csvfs_pkg;

   // code unit width
   localparam int CODE_W = 16;

   // default depth of the held whitespace memory
   localparam int HELD_DEPTH_DEF = 16;

   // separator after reset
   localparam logic [CODE_W-1:0] SEP_RESET = 16'h002C;

   // special code units
   localparam logic [CODE_W-1:0] BSLASH = 16'h005C;
   localparam logic [CODE_W-1:0] DQUOTE = 16'h0022;
   localparam logic [CODE_W-1:0] SQUOTE = 16'h0027;

   // request actions
   localparam logic ACT_UNIT = 1'b0;
   localparam logic ACT_EOL  = 1'b1;

   // result kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // unicode whitespace set used for trimming
   function automatic logic is_space(input logic [CODE_W-1:0] c);
      logic r;
      r = 1'b0;
      if (c == 16'h0020 || (c >= 16'h0009 && c <= 16'h000D)) r = 1'b1;
      if (c == 16'h0085 || c == 16'h00A0 || c == 16'h1680) r = 1'b1;
      if (c >= 16'h2000 && c <= 16'h200A) r = 1'b1;
      if (c == 16'h2028 || c == 16'h2029 || c == 16'h202F) r = 1'b1;
      if (c == 16'h205F || c == 16'h3000) r = 1'b1;
      return r;
   endfunction

endpackage

// ===== hdl/csvfs_if.sv =====
// input channel: one code unit or end of line per beat
interface csvfs_req_if;
   import csvfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [CODE_W-1:0] code_unit;
   modport source (output valid, output action, output code_unit, input ready);
   modport sink   (input valid, input action, input code_unit, output ready);
endinterface

// result channel: one field character or field end per beat
interface csvfs_rsp_if;
   import csvfs_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [CODE_W-1:0] char_out;
   logic              row_end;
   logic              space_lost;
   logic              last;
   modport source (output valid, output kind, output char_out, output row_end,
                   output space_lost, output last, input ready);
   modport sink   (input valid, input kind, input char_out, input row_end,
                   input space_lost, input last, output ready);
endinterface

// configuration channel: separator write
interface csvfs_csr_if;
   import csvfs_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] separator;
   modport source (output valid, output separator, input ready);
   modport sink   (input valid, input separator, output ready);
endinterface

// ===== hdl/csv_field_splitter_top.sv =====
// csv field splitter
// req_bus takes one beat per code unit (action 0) or end of line (action 1).
// rsp_bus gives the trimmed fields as a stream of character beats and a
// field-end beat at each separator outside quotes and at end of line; last
// marks the final beat caused by one request. csr_bus writes the separator
// and is always ready; write it only while the block is idle.
// Requests are taken one at a time. A request that makes no result (quote,
// held or dropped whitespace, backslash in quotes) leaves the block idle. A
// request that makes results is accepted and then loads its beats in order:
// the held spaces (up to HELD_SPACE_DEPTH), a kept backslash, then the
// character, or a single field-end beat; only then is a new request taken.
// Held whitespace lives in a one-port-read, one-port-write memory with a
// registered read; flushing reads one entry per cycle while rsp_bus is not stalled.
// The result register lets the next request be accepted while the last
// result still waits; a stall on rsp_bus holds the sequencer and request
// acceptance stops until the last beat of the current request is loaded.
// Reset (synchronous) clears quote, escape and field state and restores the
// separator to ','; the held memory needs no clearing.
module csv_field_splitter_top #(
   parameter int HELD_SPACE_DEPTH = csvfs_pkg::HELD_DEPTH_DEF
) (
   input logic         clock,
   input logic         reset,
   csvfs_req_if.sink   req_bus,
   csvfs_rsp_if.source rsp_bus,
   csvfs_csr_if.sink   csr_bus
);
   import csvfs_pkg::*;

   localparam int CNT_W = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int IDX_W = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FLUSH = 3'd1;
   localparam logic [2:0] ST_BS    = 3'd2;
   localparam logic [2:0] ST_CHAR  = 3'd3;
   localparam logic [2:0] ST_END   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CODE_W-1:0] sep_ff, sep_in;
   logic              quoted_ff, quoted_in;
   logic              single_ff, single_in;
   logic              escape_ff, escape_in;
   logic              started_ff, started_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              overflow_ff, overflow_in;
   logic [CODE_W-1:0] unit_ff, unit_in;
   logic              bs_ff, bs_in;
   logic              char_after_ff, char_after_in;
   logic              hold_after_ff, hold_after_in;
   logic              row_ff, row_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [CODE_W-1:0] rsp_char_ff, rsp_char_in;
   logic              rsp_row_ff, rsp_row_in;
   logic              rsp_lost_ff, rsp_lost_in;
   logic              rsp_last_ff, rsp_last_in;

   // held whitespace memory
   logic [CODE_W-1:0] held_mem [HELD_SPACE_DEPTH];
   logic [CODE_W-1:0] mem_q_ff;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [CODE_W-1:0] wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;

   logic              req_fire;
   logic              out_free;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.kind       = rsp_kind_ff;
   assign rsp_bus.char_out   = rsp_char_ff;
   assign rsp_bus.row_end    = rsp_row_ff;
   assign rsp_bus.space_lost = rsp_lost_ff;
   assign rsp_bus.last       = rsp_last_ff;

   // decode and result sequencing
   always_comb begin
      logic              do_bs;
      logic              do_c;
      logic              do_end;
      logic              eol_row;
      logic              ws;
      logic [CODE_W-1:0] c;
      logic [CODE_W-1:0] q;
      logic [CNT_W-1:0]  next_ptr;

      state_in      = state_ff;
      sep_in        = sep_ff;
      quoted_in     = quoted_ff;
      single_in     = single_ff;
      escape_in     = escape_ff;
      started_in    = started_ff;
      count_in      = count_ff;
      overflow_in   = overflow_ff;
      unit_in       = unit_ff;
      bs_in         = bs_ff;
      char_after_in = char_after_ff;
      hold_after_in = hold_after_ff;
      row_in        = row_ff;
      rd_ptr_in     = rd_ptr_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_lost_in   = rsp_lost_ff;
      rsp_last_in   = rsp_last_ff;

      wr_en    = 1'b0;
      wr_addr  = count_ff[IDX_W-1:0];
      wr_data  = req_bus.code_unit;
      rd_en    = 1'b0;
      rd_addr  = '0;

      do_bs    = 1'b0;
      do_c     = 1'b0;
      do_end   = 1'b0;
      eol_row  = 1'b0;
      c        = req_bus.code_unit;
      q        = single_ff ? SQUOTE : DQUOTE;
      ws       = is_space(req_bus.code_unit);
      next_ptr = CNT_W'(rd_ptr_ff) + CNT_W'(1);

      // separator write
      if (csr_bus.valid) begin
         sep_in = csr_bus.separator;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // classify the beat against quote and escape state
               if (req_bus.action == ACT_EOL) begin
                  do_end    = 1'b1;
                  eol_row   = 1'b1;
                  quoted_in = 1'b0;
                  single_in = 1'b0;
                  escape_in = 1'b0;
               end else if (quoted_ff) begin
                  if (escape_ff) begin
                     do_bs     = (c != q) && (c != BSLASH);
                     do_c      = 1'b1;
                     escape_in = 1'b0;
                  end else if (c == BSLASH) begin
                     escape_in = 1'b1;
                  end else if (c == q) begin
                     quoted_in = 1'b0;
                     single_in = 1'b0;
                  end else begin
                     do_c = 1'b1;
                  end
               end else if (c == sep_ff) begin
                  do_end = 1'b1;
               end else if (c == DQUOTE || c == SQUOTE) begin
                  quoted_in = 1'b1;
                  single_in = (c == SQUOTE);
               end else begin
                  do_c = 1'b1;
               end

               // plan the result beats
               if (do_bs) begin
                  unit_in       = c;
                  bs_in         = 1'b1;
                  char_after_in = !ws;
                  hold_after_in = ws;
                  if (count_ff != '0) begin
                     rd_en     = 1'b1;
                     rd_ptr_in = '0;
                     state_in  = ST_FLUSH;
                  end else begin
                     state_in = ST_BS;
                  end
               end else if (do_c && ws) begin
                  // hold inner whitespace, drop leading whitespace
                  if (started_ff) begin
                     if (count_ff < CNT_W'(HELD_SPACE_DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
               end else if (do_c) begin
                  unit_in       = c;
                  bs_in         = 1'b0;
                  char_after_in = 1'b1;
                  hold_after_in = 1'b0;
                  if (count_ff != '0) begin
                     rd_en     = 1'b1;
                     rd_ptr_in = '0;
                     state_in  = ST_FLUSH;
                  end else begin
                     state_in = ST_CHAR;
                  end
               end else if (do_end) begin
                  row_in   = eol_row;
                  state_in = ST_END;
               end
            end
         end

         ST_FLUSH: begin
            // one held unit per beat, next entry fetched alongside
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_char_in  = mem_q_ff;
               rsp_row_in   = 1'b0;
               rsp_lost_in  = 1'b0;
               rsp_last_in  = 1'b0;
               if (next_ptr < count_ff) begin
                  rd_en     = 1'b1;
                  rd_addr   = next_ptr[IDX_W-1:0];
                  rd_ptr_in = next_ptr[IDX_W-1:0];
               end else begin
                  state_in = bs_ff ? ST_BS : ST_CHAR;
               end
            end
         end

         ST_BS: begin
            // kept backslash, then the unit after it is sent or, if whitespace, held
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_char_in  = BSLASH;
               rsp_row_in   = 1'b0;
               rsp_lost_in  = 1'b0;
               rsp_last_in  = !char_after_ff;
               started_in   = 1'b1;
               count_in     = '0;
               if (hold_after_ff) begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  wr_data  = unit_ff;
                  count_in = CNT_W'(1);
               end
               state_in = char_after_ff ? ST_CHAR : ST_IDLE;
            end
         end

         ST_CHAR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_char_in  = unit_ff;
               rsp_row_in   = 1'b0;
               rsp_lost_in  = 1'b0;
               rsp_last_in  = 1'b1;
               started_in   = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end

         ST_END: begin
            // field end clears the per-field state
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_END;
               rsp_char_in  = '0;
               rsp_row_in   = row_ff;
               rsp_lost_in  = overflow_ff;
               rsp_last_in  = 1'b1;
               started_in   = 1'b0;
               count_in     = '0;
               overflow_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sep_ff       <= SEP_RESET;
         quoted_ff    <= 1'b0;
         single_ff    <= 1'b0;
         escape_ff    <= 1'b0;
         started_ff   <= 1'b0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sep_ff       <= sep_in;
         quoted_ff    <= quoted_in;
         single_ff    <= single_in;
         escape_ff    <= escape_in;
         started_ff   <= started_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      unit_ff       <= unit_in;
      bs_ff         <= bs_in;
      char_after_ff <= char_after_in;
      hold_after_ff <= hold_after_in;
      row_ff        <= row_in;
      rd_ptr_ff     <= rd_ptr_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_lost_ff   <= rsp_lost_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // held memory: writes and flush reads never share a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         held_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff <= held_mem[rd_addr];
      end
   end

endmodule

// ===== hdl/csvfs_checker.sv =====
module csvfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_action,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_kind,
   input logic [15:0] rsp_char_out,
   input logic        rsp_row_end,
   input logic        rsp_space_lost,
   input logic        rsp_last
);
   import csvfs_pkg::*;

   // stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_out)
         && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // end of line always leaves a field end to send, so no beat follows at once
   a_eol_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACT_EOL |=> !req_ready)
      else $error("request taken right after end of line");

   // field end closes its request and carries no character
   a_end_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_END |-> rsp_last && rsp_char_out == '0)
      else $error("malformed field end");

   // row close and overflow flag only on field ends
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_row_end || rsp_space_lost) |-> rsp_kind == KIND_END)
      else $error("field flag on a character beat");

endmodule

bind csv_field_splitter_top csvfs_checker u_csvfs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_action     (req_bus.action),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_char_out   (rsp_bus.char_out),
   .rsp_row_end    (rsp_bus.row_end),
   .rsp_space_lost (rsp_bus.space_lost),
   .rsp_last       (rsp_bus.last)
);
